// ----- hdl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int N_TASKS_DEF     = 4;
	localparam int NUM_PERIOD_REGS = 4;
	localparam int PREG_IDX_W      = 2;
	localparam int PERIOD_W        = 16;
	localparam int RUNS_W          = 32;
	localparam int ACT_W           = 3;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int MASK_W          = 4;
	localparam int COUNT_W         = 3;
	localparam int SEL_W           = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd4;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] countdown;
		logic [RUNS_W-1:0]   runs;
		logic                fired;
	} alu_res_t;

endpackage

// ----- hdl/pts_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pts_cfg_regs
// Period and active-count registers with a period lookup for one table entry.
// ----------------------------------------------------------------------------
module pts_cfg_regs #(
	parameter int N_TASKS = pts_pkg::N_TASKS_DEF,
	parameter int IDX_W   = (N_TASKS > 1) ? $clog2(N_TASKS) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [IDX_W-1:0]                rd_idx,
	output logic [pts_pkg::PERIOD_W-1:0]   period,
	output logic [pts_pkg::ACT_W-1:0]      active
);

	logic [pts_pkg::PERIOD_W-1:0] period_q [pts_pkg::NUM_PERIOD_REGS];
	logic [pts_pkg::ACT_W-1:0]    active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pts_pkg::NUM_PERIOD_REGS; i++) begin
				period_q[i] <= pts_pkg::PERIOD_W'(1);
			end
			active_q <= pts_pkg::ACT_W'(4);
		end else if (cfg_we) begin
			if (cfg_index < pts_pkg::CFG_IDX_W'(pts_pkg::NUM_PERIOD_REGS)) begin
				if (32'(cfg_index) < N_TASKS) begin
					period_q[cfg_index[pts_pkg::PREG_IDX_W-1:0]] <=
						cfg_data[pts_pkg::PERIOD_W-1:0];
				end
			end else if (cfg_index == pts_pkg::REG_ACTIVE) begin
				active_q <= cfg_data[pts_pkg::ACT_W-1:0];
			end
		end
	end

	// entries past the period registers reload with 1
	always_comb begin
		period = pts_pkg::PERIOD_W'(1);
		for (int i = 0; i < pts_pkg::NUM_PERIOD_REGS; i++) begin
			if (i < N_TASKS && 32'(rd_idx) == i) begin
				period = period_q[i];
			end
		end
	end

	assign active = active_q;

endmodule

// ----- hdl/pts_task_alu.sv -----
// ----------------------------------------------------------------------------
// pts_task_alu
// Shared per-entry unit: countdown decrement, zero test, reload, run count and restart.
// ----------------------------------------------------------------------------
module pts_task_alu (
	input  logic [pts_pkg::PERIOD_W-1:0] countdown,
	input  logic [pts_pkg::RUNS_W-1:0]   runs,
	input  logic [pts_pkg::PERIOD_W-1:0] period,
	input  pts_pkg::op_t                 op,
	input  logic                         entry_active,
	output pts_pkg::alu_res_t            res
);

	logic [pts_pkg::PERIOD_W-1:0] dec;

	assign dec = (countdown != '0) ? countdown - pts_pkg::PERIOD_W'(1) : '0;

	always_comb begin
		res.countdown = countdown;
		res.runs      = runs;
		res.fired     = 1'b0;
		if (op == pts_pkg::OP_RESTART) begin
			res.countdown = period;
			res.runs      = '0;
		end else if (entry_active) begin
			if (dec == '0) begin
				res.countdown = period;
				res.runs      = runs + pts_pkg::RUNS_W'(1);
				res.fired     = 1'b1;
			end else begin
				res.countdown = dec;
			end
		end
	end

endmodule

// ----- hdl/pts_seq.sv -----
// ----------------------------------------------------------------------------
// pts_seq
// Sequencer: walks the task table one entry per cycle through the shared unit
// and posts the result into the output register.
// ----------------------------------------------------------------------------
module pts_seq #(
	parameter int N_TASKS = pts_pkg::N_TASKS_DEF,
	parameter int IDX_W   = (N_TASKS > 1) ? $clog2(N_TASKS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [pts_pkg::SEL_W-1:0]    task_select,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pts_pkg::COUNT_W-1:0]  fired_count,
	output logic [pts_pkg::MASK_W-1:0]   fired_mask,
	output logic [pts_pkg::RUNS_W-1:0]   selected_runs,
	output logic [IDX_W-1:0]              rd_idx,
	input  logic [pts_pkg::PERIOD_W-1:0] period,
	input  logic [pts_pkg::ACT_W-1:0]    active
);

	pts_pkg::state_t state_q, state_d;

	logic [pts_pkg::PERIOD_W-1:0] countdown_q [N_TASKS];
	logic [pts_pkg::RUNS_W-1:0]   runs_q      [N_TASKS];

	logic [IDX_W-1:0]             idx_q;
	pts_pkg::op_t                 op_q;
	logic [pts_pkg::SEL_W-1:0]    sel_q;
	logic [pts_pkg::MASK_W-1:0]   mask_q;
	logic [pts_pkg::COUNT_W-1:0]  count_q;
	logic [pts_pkg::RUNS_W-1:0]   sel_runs_q;

	logic                         out_valid_q;
	logic [pts_pkg::COUNT_W-1:0]  out_count_q;
	logic [pts_pkg::MASK_W-1:0]   out_mask_q;
	logic [pts_pkg::RUNS_W-1:0]   out_runs_q;

	logic              last;
	logic              out_free;
	logic              accept;
	logic              walk;
	logic              load_out;
	logic              entry_active;
	pts_pkg::alu_res_t res;

	assign last         = (32'(idx_q) == N_TASKS - 1);
	assign out_free     = !out_valid_q || !out_stall;
	assign accept       = in_valid && !in_stall;
	assign entry_active = (32'(idx_q) < 32'(active));
	assign rd_idx       = idx_q;

	pts_task_alu u_alu (
		.countdown    (countdown_q[idx_q]),
		.runs         (runs_q[idx_q]),
		.period       (period),
		.op           (op_q),
		.entry_active (entry_active),
		.res          (res)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pts_pkg::S_IDLE:  if (in_valid) state_d = pts_pkg::S_WALK;
			pts_pkg::S_WALK:  if (last) state_d = pts_pkg::S_FLUSH;
			pts_pkg::S_FLUSH: if (out_free) state_d = pts_pkg::S_IDLE;
			default:          state_d = pts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		walk     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			pts_pkg::S_IDLE:  in_stall = 1'b0;
			pts_pkg::S_WALK:  walk = 1'b1;
			pts_pkg::S_FLUSH: load_out = out_free;
			default:          in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// task table walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_TASKS; i++) begin
				countdown_q[i] <= '0;
				runs_q[i]      <= '0;
			end
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (walk) begin
			countdown_q[idx_q] <= res.countdown;
			runs_q[idx_q]      <= res.runs;
			idx_q              <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= pts_pkg::op_t'(op);
			sel_q      <= task_select;
			mask_q     <= '0;
			count_q    <= '0;
			sel_runs_q <= '0;
		end else if (walk) begin
			if (res.fired) begin
				count_q <= count_q + pts_pkg::COUNT_W'(1);
			end
			for (int j = 0; j < pts_pkg::MASK_W; j++) begin
				if (res.fired && 32'(idx_q) == j) begin
					mask_q[j] <= 1'b1;
				end
			end
			if (32'(sel_q) == 32'(idx_q)) begin
				sel_runs_q <= res.runs;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q <= count_q;
			out_mask_q  <= mask_q;
			out_runs_q  <= sel_runs_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign fired_count   = out_count_q;
	assign fired_mask    = out_mask_q;
	assign selected_runs = out_runs_q;

endmodule

// ----- hdl/periodic_task_tick_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Table of periodic tasks with reload periods, countdowns and run counters.
// ----------------------------------------------------------------------------
// Each transfer on the input side is a tick or a restart. The block walks its
// N_TASKS table entries one per cycle through a single shared countdown and
// run-count unit, then posts the result into the output register. A new item
// is taken only after the post: the idle state takes the transfer, then come
// the walk and the post. The input stalls for the walk and the post; a posted
// result waits in the output register while the next item is taken in, and a
// walk that finishes while that result is still stalled holds in its post
// step until the register frees. Configuration writes are to be made only
// while the block is idle; the block itself does not enforce this.
module periodic_task_tick_scheduler_top #(
	parameter int N_TASKS = pts_pkg::N_TASKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [pts_pkg::SEL_W-1:0]      task_select,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pts_pkg::COUNT_W-1:0]    fired_count,
	output logic [pts_pkg::MASK_W-1:0]     fired_mask,
	output logic [pts_pkg::RUNS_W-1:0]     selected_runs
);

	localparam int IDX_W = (N_TASKS > 1) ? $clog2(N_TASKS) : 1;

	logic [IDX_W-1:0]             rd_idx;
	logic [pts_pkg::PERIOD_W-1:0] period;
	logic [pts_pkg::ACT_W-1:0]    active;

	pts_cfg_regs #(
		.N_TASKS (N_TASKS),
		.IDX_W   (IDX_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_idx    (rd_idx),
		.period    (period),
		.active    (active)
	);

	pts_seq #(
		.N_TASKS (N_TASKS),
		.IDX_W   (IDX_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.task_select   (task_select),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fired_count   (fired_count),
		.fired_mask    (fired_mask),
		.selected_runs (selected_runs),
		.rd_idx        (rd_idx),
		.period        (period),
		.active        (active)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a walk is starting");

	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (N_TASKS <= pts_pkg::MASK_W) |->
			pts_pkg::COUNT_W'($countones(fired_mask)) == fired_count)
		else $error("fired count disagrees with fired mask");

	a_no_result_while_idle_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_stall |=> !out_valid)
		else $error("result appeared without a walk");

endmodule
